// ----- rtl/ffea_pkg.sv -----
// Shared types, codes and constants of the first-fit extent allocator.
`default_nettype none
package ffea_pkg;

   localparam int START_W = 16;
   localparam int LEN_W   = 17;
   localparam int CMD_W   = 2;
   localparam int FRAME_W = 3;
   localparam int STAT_W  = 3;

   localparam logic [LEN_W-1:0] CAP_RESET  = 17'd1024;
   localparam logic [LEN_W-1:0] SLOT_SPACE = 17'h10000;

   localparam int DEF_MAX_EXTENTS = 32;
   localparam int DEF_FRAMES      = 3;
   localparam int DEF_DEFER_DEPTH = 16;

   // Request command codes.
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd2;

   // Response status codes.
   localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE   = 3'd1;
   localparam logic [STAT_W-1:0] ST_ZERO_LEN   = 3'd2;
   localparam logic [STAT_W-1:0] ST_LIST_FULL  = 3'd3;
   localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd4;

   // Operation broadcast to every cell of the extent row.
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_INIT,
      OP_ALLOC,
      OP_EXTEND,
      OP_PLACE,
      OP_REPLACE,
      OP_MERGE
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [START_W-1:0]   s;
      logic [LEN_W-1:0]     e;
      logic [LEN_W-1:0]     len;
   } cell_cmd_type;

   typedef struct packed {
      logic                 valid;
      logic [START_W-1:0]   start;
      logic [LEN_W-1:0]     len;
   } extent_type;

   // Signals rippling from the low cell towards the high cell.
   typedef struct packed {
      logic le;
      logic fit_seen;
      logic rm;
      logic mg;
   } chain_type;

   typedef struct packed {
      logic                 first_fit;
      logic                 is_prev;
      logic                 is_atp;
      logic                 merge_here;
      logic [START_W-1:0]   start;
      logic [LEN_W-1:0]     end_pos;
   } cell_report_type;

   typedef struct packed {
      logic [START_W-1:0]   start;
      logic [LEN_W-1:0]     len;
   } defer_entry_type;

endpackage
`default_nettype wire

// ----- rtl/ffea_req_if.sv -----
// Request channel of the extent allocator.
`default_nettype none
interface ffea_req_if;
   import ffea_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [LEN_W-1:0]     length;
   logic [START_W-1:0]   start_index;
   logic [FRAME_W-1:0]   frame;
   modport source (output valid, command, length, start_index, frame, input ready);
   modport sink (input valid, command, length, start_index, frame, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffea_rsp_if.sv -----
// Response channel of the extent allocator.
`default_nettype none
interface ffea_rsp_if;
   import ffea_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic [START_W-1:0]   base_index;
   logic [LEN_W-1:0]     used_count;
   modport source (output valid, status, base_index, used_count, input ready);
   modport sink (input valid, status, base_index, used_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/ffea_cell.sv -----
// One cell of the sorted free-extent row.
`default_nettype none
module ffea_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      lead,
   input  ffea_pkg::cell_cmd_type         cmd,
   input  ffea_pkg::extent_type           left_ext,
   input  ffea_pkg::extent_type           right_ext,
   input  ffea_pkg::chain_type            left_chain,
   input  wire logic                      right_le,
   output ffea_pkg::chain_type            right_chain,
   output ffea_pkg::extent_type           ext_out,
   output ffea_pkg::cell_report_type      report
);
   import ffea_pkg::*;

   extent_type         ext_ff, ext_in;
   logic               head_ff, head_in;
   logic [LEN_W-1:0]   end_v, right_end, new_end;
   logic               le, fit, first, rm_here, merge_here, is_prev, is_atp;

   // Local compares against the broadcast range and the neighbors.
   always_comb begin
      end_v      = LEN_W'(ext_ff.start) + ext_ff.len;
      right_end  = LEN_W'(right_ext.start) + right_ext.len;
      le         = ext_ff.valid && (ext_ff.start <= cmd.s);
      fit        = ext_ff.valid && (ext_ff.len >= cmd.len);
      first      = fit && !left_chain.fit_seen;
      rm_here    = first && (ext_ff.len == cmd.len);
      merge_here = head_ff && right_ext.valid && (LEN_W'(right_ext.start) <= end_v);
      is_prev    = le && !right_le;
      is_atp     = ext_ff.valid && !le && left_chain.le;
      right_chain.le       = le;
      right_chain.fit_seen = left_chain.fit_seen || fit;
      right_chain.rm       = left_chain.rm || rm_here;
      right_chain.mg       = left_chain.mg || merge_here;
      report.first_fit  = first;
      report.is_prev    = is_prev;
      report.is_atp     = is_atp;
      report.merge_here = merge_here;
      report.start      = ext_ff.start;
      report.end_pos    = end_v;
   end

   // Apply the broadcast operation to this cell.
   always_comb begin
      ext_in  = ext_ff;
      head_in = head_ff;
      new_end = end_v;
      case (cmd.op)
         OP_INIT: begin
            ext_in.valid = lead;
            ext_in.start = '0;
            ext_in.len   = cmd.len;
            head_in      = 1'b0;
         end
         OP_ALLOC: begin
            if (rm_here || left_chain.rm) begin
               ext_in = right_ext;
            end else if (first) begin
               ext_in.start = START_W'(LEN_W'(ext_ff.start) + cmd.len);
               ext_in.len   = ext_ff.len - cmd.len;
            end
         end
         OP_EXTEND: begin
            if (is_prev) begin
               new_end    = (cmd.e > end_v) ? cmd.e : end_v;
               ext_in.len = new_end - LEN_W'(ext_ff.start);
               head_in    = 1'b1;
            end
         end
         OP_PLACE: begin
            if (!le) begin
               if (left_chain.le) begin
                  ext_in.valid = 1'b1;
                  ext_in.start = cmd.s;
                  ext_in.len   = cmd.len;
                  head_in      = 1'b1;
               end else begin
                  ext_in  = left_ext;
                  head_in = 1'b0;
               end
            end
         end
         OP_REPLACE: begin
            if (is_atp) begin
               new_end      = (cmd.e > end_v) ? cmd.e : end_v;
               ext_in.start = cmd.s;
               ext_in.len   = new_end - LEN_W'(cmd.s);
               head_in      = 1'b1;
            end
         end
         OP_MERGE: begin
            if (merge_here) begin
               new_end    = (right_end > end_v) ? right_end : end_v;
               ext_in.len = new_end - LEN_W'(ext_ff.start);
            end else if (head_ff) begin
               head_in = 1'b0;
            end
            if (left_chain.mg) begin
               ext_in = right_ext;
            end
         end
         default: begin
         end
      endcase
   end

   // Hold the extent; reset leaves one extent over the default capacity.
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff.valid <= lead;
         ext_ff.start <= '0;
         ext_ff.len   <= CAP_RESET;
         head_ff      <= 1'b0;
      end else begin
         ext_ff  <= ext_in;
         head_ff <= head_in;
      end
   end

   assign ext_out = ext_ff;

endmodule
`default_nettype wire

// ----- rtl/ffea_defer_mem.sv -----
// Deferred-free range store: one write port, one registered read port.
`default_nettype none
module ffea_defer_mem #(
   parameter int ENTRIES = 48,
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  ffea_pkg::defer_entry_type  wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output ffea_pkg::defer_entry_type  rd_data
);
   import ffea_pkg::*;

   defer_entry_type mem_ff [ENTRIES];
   defer_entry_type rd_data_ff;

   // Write and read in the same clocked block.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/first_fit_extent_allocator.sv -----
// First-fit extent allocator: a request is answered by exactly one response word.
// Channels: req_if carries command, length, start_index and frame; rsp_if returns
// status, base_index and used_count. Both use valid/ready; a word moves when both
// are high. csr_wr_en with csr_wr_data writes the capacity (clamped to 1..65536)
// and reinitializes the table, the deferred lists and the in-use count.
// One request is handled at a time. An allocate goes from decode through the
// allocate step to the response; an allocate rejected at decode, a free, an
// unknown command and a process of a frame outside the lists go from decode
// straight to the response. A process reads, loads, classifies and applies each
// queued range in turn, then coalesces at most MAX_EXTENTS extents for it; merges
// walk the cell row one extent per cycle. A process that hits a full table copies
// each range left queued to the front of its list.
// Reset leaves one free extent of 1024 slots, empty lists and no slots in use.
// The response sits in an output register; while the receiver stalls, the next
// request may still be accepted, and its response waits until the first leaves.
`default_nettype none
module first_fit_extent_allocator #(
   parameter int MAX_EXTENTS = ffea_pkg::DEF_MAX_EXTENTS,
   parameter int FRAMES      = ffea_pkg::DEF_FRAMES,
   parameter int DEFER_DEPTH = ffea_pkg::DEF_DEFER_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   ffea_req_if.sink                        req_if,
   ffea_rsp_if.source                      rsp_if,
   input  wire logic                       csr_wr_en,
   input  wire logic [ffea_pkg::LEN_W-1:0] csr_wr_data
);
   import ffea_pkg::*;

   localparam int FW  = $clog2(DEFER_DEPTH + 1);
   localparam int FIW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int ENTRIES = FRAMES * DEFER_DEPTH;
   localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_ALLOC, S_RD, S_LOAD, S_CLASS, S_APPLY,
      S_MERGE, S_CP_RD, S_CP_WR, S_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [START_W-1:0]  s_ff, s_in;
   logic [FRAME_W-1:0]  fr_ff, fr_in;
   logic [LEN_W-1:0]    cap_ff, cap_in;
   logic [LEN_W-1:0]    slots_ff, slots_in;
   logic [FW-1:0]       fill_ff [FRAMES];
   logic [FW-1:0]       fill_in [FRAMES];
   logic [FW-1:0]       i_ff, i_in, k_ff, k_in, n_ff, n_in;
   logic [START_W-1:0]  cur_s_ff, cur_s_in;
   logic [LEN_W-1:0]    cur_len_ff, cur_len_in, cur_e_ff, cur_e_in;
   cell_op_type         apply_op_ff, apply_op_in;
   logic [STAT_W-1:0]   pend_status_ff, pend_status_in;
   logic [START_W-1:0]  pend_base_ff, pend_base_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]  rsp_base_ff, rsp_base_in;
   logic [LEN_W-1:0]    rsp_used_ff, rsp_used_in;

   logic [FIW-1:0]      fidx;
   logic                frame_bad;
   logic [FW-1:0]       fill_cur;
   logic [LEN_W:0]      alloc_sum;
   logic [LEN_W-1:0]    room, clip_len, clamp_cap;

   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   defer_entry_type     mem_wdata, mem_rdata;

   cell_cmd_type        cell_cmd;
   extent_type          ext_q   [MAX_EXTENTS];
   chain_type           chain_q [MAX_EXTENTS+1];
   cell_report_type     rep_q   [MAX_EXTENTS];

   logic                hit_any, prev_any, atp_any, merge_any;
   logic [START_W-1:0]  hit_base, atp_start;
   logic [LEN_W-1:0]    prev_end;

   function automatic logic [AW-1:0] defer_addr(input logic [FIW-1:0] f,
                                                input logic [FW-1:0] slot);
      return AW'(int'(f) * DEFER_DEPTH + int'(slot));
   endfunction

   // Row of extent cells; the low cell sees a "less-or-equal" of one on its left.
   assign chain_q[0] = '{le: 1'b1, fit_seen: 1'b0, rm: 1'b0, mg: 1'b0};

   for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
      extent_type left_ext, right_ext;
      logic       right_le;
      if (g == 0) begin : g_lo
         assign left_ext = '0;
      end else begin : g_mid_lo
         assign left_ext = ext_q[g-1];
      end
      if (g == MAX_EXTENTS - 1) begin : g_hi
         assign right_ext = '0;
         assign right_le  = 1'b0;
      end else begin : g_mid_hi
         assign right_ext = ext_q[g+1];
         assign right_le  = chain_q[g+2].le;
      end
      ffea_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .lead        (g == 0),
         .cmd         (cell_cmd),
         .left_ext    (left_ext),
         .right_ext   (right_ext),
         .left_chain  (chain_q[g]),
         .right_le    (right_le),
         .right_chain (chain_q[g+1]),
         .ext_out     (ext_q[g]),
         .report      (rep_q[g])
      );
   end

   // Gather the cell reports; at most one cell raises each flag.
   always_comb begin
      hit_any   = 1'b0;
      prev_any  = 1'b0;
      atp_any   = 1'b0;
      merge_any = 1'b0;
      hit_base  = '0;
      atp_start = '0;
      prev_end  = '0;
      for (int c = 0; c < MAX_EXTENTS; c++) begin
         hit_any   = hit_any | rep_q[c].first_fit;
         prev_any  = prev_any | rep_q[c].is_prev;
         atp_any   = atp_any | rep_q[c].is_atp;
         merge_any = merge_any | rep_q[c].merge_here;
         hit_base  = hit_base | (rep_q[c].first_fit ? rep_q[c].start : '0);
         atp_start = atp_start | (rep_q[c].is_atp ? rep_q[c].start : '0);
         prev_end  = prev_end | (rep_q[c].is_prev ? rep_q[c].end_pos : '0);
      end
   end

   ffea_defer_mem #(.ENTRIES(ENTRIES)) u_defer_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Request-derived helpers.
   always_comb begin
      fidx      = fr_ff[FIW-1:0];
      frame_bad = ({1'b0, fr_ff} >= (FRAME_W+1)'(FRAMES));
      fill_cur  = frame_bad ? '0 : fill_ff[fidx];
      alloc_sum = (LEN_W+1)'(slots_ff) + (LEN_W+1)'(len_ff);
      room      = SLOT_SPACE - LEN_W'(s_ff);
      clip_len  = (len_ff > room) ? room : len_ff;
      if (csr_wr_data == '0) begin
         clamp_cap = LEN_W'(1);
      end else if (csr_wr_data > SLOT_SPACE) begin
         clamp_cap = SLOT_SPACE;
      end else begin
         clamp_cap = csr_wr_data;
      end
   end

   // Sequencer: next state, list control and the response register.
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      len_in         = len_ff;
      s_in           = s_ff;
      fr_in          = fr_ff;
      cap_in         = cap_ff;
      slots_in       = slots_ff;
      fill_in        = fill_ff;
      i_in           = i_ff;
      k_in           = k_ff;
      n_in           = n_ff;
      cur_s_in       = cur_s_ff;
      cur_len_in     = cur_len_ff;
      cur_e_in       = cur_e_ff;
      apply_op_in    = apply_op_ff;
      pend_status_in = pend_status_ff;
      pend_base_in   = pend_base_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_base_in    = rsp_base_ff;
      rsp_used_in    = rsp_used_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = defer_addr(fidx, k_ff);
      mem_raddr      = defer_addr(fidx, i_ff);
      mem_wdata      = mem_rdata;
      cell_cmd.op    = OP_IDLE;
      cell_cmd.s     = cur_s_ff;
      cell_cmd.e     = cur_e_ff;
      cell_cmd.len   = cur_len_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               cmd_in   = req_if.command;
               len_in   = req_if.length;
               s_in     = req_if.start_index;
               fr_in    = req_if.frame;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            pend_status_in = ST_OK;
            pend_base_in   = '0;
            state_in       = S_RESP;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (len_ff == '0) begin
                     pend_status_in = ST_ZERO_LEN;
                  end else if (alloc_sum > (LEN_W+1)'(cap_ff)) begin
                     pend_status_in = ST_NO_SPACE;
                  end else begin
                     state_in = S_ALLOC;
                  end
               end
               CMD_FREE: begin
                  if (len_ff == '0) begin
                     pend_status_in = ST_ZERO_LEN;
                  end else if (frame_bad || (fill_cur >= FW'(DEFER_DEPTH))) begin
                     pend_status_in = ST_LIST_FULL;
                  end else begin
                     mem_we          = 1'b1;
                     mem_waddr       = defer_addr(fidx, fill_cur);
                     mem_wdata.start = s_ff;
                     mem_wdata.len   = clip_len;
                     fill_in[fidx]   = fill_cur + FW'(1);
                  end
               end
               CMD_PROCESS: begin
                  if (!frame_bad) begin
                     n_in     = fill_cur;
                     i_in     = '0;
                     state_in = S_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_ALLOC: begin
            cell_cmd.op  = OP_ALLOC;
            cell_cmd.len = len_ff;
            if (hit_any) begin
               pend_base_in = hit_base;
               slots_in     = slots_ff + len_ff;
            end else begin
               pend_status_in = ST_NO_SPACE;
            end
            state_in = S_RESP;
         end
         S_RD: begin
            if (i_ff == n_ff) begin
               fill_in[fidx] = '0;
               state_in      = S_RESP;
            end else begin
               mem_re   = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cur_s_in   = mem_rdata.start;
            cur_len_in = mem_rdata.len;
            cur_e_in   = LEN_W'(mem_rdata.start) + mem_rdata.len;
            state_in   = S_CLASS;
         end
         S_CLASS: begin
            state_in = S_APPLY;
            if (prev_any && (prev_end >= LEN_W'(cur_s_ff))) begin
               apply_op_in = OP_EXTEND;
            end else if (!ext_q[MAX_EXTENTS-1].valid) begin
               apply_op_in = OP_PLACE;
            end else if (atp_any && (cur_e_ff >= LEN_W'(atp_start))) begin
               apply_op_in = OP_REPLACE;
            end else begin
               pend_status_in = ST_TABLE_FULL;
               k_in           = '0;
               state_in       = S_CP_RD;
            end
         end
         S_APPLY: begin
            cell_cmd.op = apply_op_ff;
            state_in    = S_MERGE;
         end
         S_MERGE: begin
            cell_cmd.op = OP_MERGE;
            if (!merge_any) begin
               slots_in = (slots_ff >= cur_len_ff) ? (slots_ff - cur_len_ff) : '0;
               i_in     = i_ff + FW'(1);
               state_in = S_RD;
            end
         end
         S_CP_RD: begin
            if ((FW+1)'(i_ff) + (FW+1)'(k_ff) == (FW+1)'(n_ff)) begin
               fill_in[fidx] = k_ff;
               state_in      = S_RESP;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = defer_addr(fidx, FW'(i_ff + k_ff));
               state_in  = S_CP_WR;
            end
         end
         S_CP_WR: begin
            mem_we   = 1'b1;
            k_in     = k_ff + FW'(1);
            state_in = S_CP_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_base_in   = pend_base_ff;
               rsp_used_in   = slots_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Capacity write reinitializes table, lists and count.
      if (csr_wr_en) begin
         cap_in       = clamp_cap;
         slots_in     = '0;
         cell_cmd.op  = OP_INIT;
         cell_cmd.len = clamp_cap;
         for (int f = 0; f < FRAMES; f++) begin
            fill_in[f] = '0;
         end
      end
   end

   // Hold state, counters and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         slots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int f = 0; f < FRAMES; f++) begin
            fill_ff[f] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         slots_ff     <= slots_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
      cmd_ff         <= cmd_in;
      len_ff         <= len_in;
      s_ff           <= s_in;
      fr_ff          <= fr_in;
      i_ff           <= i_in;
      k_ff           <= k_in;
      n_ff           <= n_in;
      cur_s_ff       <= cur_s_in;
      cur_len_ff     <= cur_len_in;
      cur_e_ff       <= cur_e_in;
      apply_op_ff    <= apply_op_in;
      pend_status_ff <= pend_status_in;
      pend_base_ff   <= pend_base_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_base_ff    <= rsp_base_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign req_if.ready      = (state_ff == S_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.base_index = rsp_base_ff;
   assign rsp_if.used_count = rsp_used_ff;

   // An accepted request always leaves idle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // Slots in use never exceed the capacity.
   a_used_le_cap: assert property (@(posedge clock) disable iff (reset)
      slots_ff <= cap_ff)
      else $error("slots in use exceed capacity");

   // The first deferred list never overfills.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff[0] <= FW'(DEFER_DEPTH))
      else $error("deferred list fill beyond depth");

   // Coalescing only happens in the merge walk.
   a_merge_phase: assert property (@(posedge clock) disable iff (reset)
      merge_any |-> (state_ff == S_MERGE))
      else $error("merge raised outside the merge walk");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench of the first-fit extent allocator.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import ffea_pkg::*;

   localparam int NEXT  = 32;
   localparam int NFR   = 3;
   localparam int DDEP  = 16;
   localparam int LIMIT = 10000000;

   // Command code the block ignores.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [START_W-1:0] base;
      logic [LEN_W-1:0]   used;
   } rsp_word_type;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [LEN_W-1:0]   len;
      logic [START_W-1:0] s;
      logic [FRAME_W-1:0] fr;
      bit                 fixed;
      rsp_word_type       want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [LEN_W-1:0] csr_wr_data = '0;

   ffea_req_if req_if ();
   ffea_rsp_if rsp_if ();

   first_fit_extent_allocator uut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // Allocator shadow state
   int unsigned cap;
   int unsigned ext_s [NEXT];
   int unsigned ext_l [NEXT];
   int unsigned ext_n;
   int unsigned dq_s [NFR][DDEP];
   int unsigned dq_l [NFR][DDEP];
   int unsigned dq_n [NFR];
   int unsigned in_use;

   rsp_word_type pending_rsp[$];
   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_stall = 0;
   int hold_cycles = 0;

   function automatic void shadow_init();
      ext_s[0] = 0;
      ext_l[0] = cap;
      ext_n = 1;
      for (int f = 0; f < NFR; f++) dq_n[f] = 0;
      in_use = 0;
   endfunction

   function automatic void drop_extent(int unsigned i);
      for (int unsigned k = i; k + 1 < ext_n; k++) begin
         ext_s[k] = ext_s[k+1];
         ext_l[k] = ext_l[k+1];
      end
      ext_n--;
   endfunction

   function automatic bit return_range(int unsigned s, int unsigned len);
      int unsigned e, p, idx, ce;
      e = s + len;
      p = 0;
      while (p < ext_n && ext_s[p] <= s) p++;
      if (p > 0 && ext_s[p-1] + ext_l[p-1] >= s) begin
         idx = p - 1;
         ce = ext_s[idx] + ext_l[idx];
         if (e > ce) ext_l[idx] = e - ext_s[idx];
      end else if (ext_n < NEXT) begin
         for (int unsigned k = ext_n; k > p; k--) begin
            ext_s[k] = ext_s[k-1];
            ext_l[k] = ext_l[k-1];
         end
         ext_s[p] = s;
         ext_l[p] = len;
         ext_n++;
         idx = p;
      end else if (p < ext_n && e >= ext_s[p]) begin
         ce = ext_s[p] + ext_l[p];
         if (e < ce) e = ce;
         ext_s[p] = s;
         ext_l[p] = e - s;
         idx = p;
      end else begin
         return 1'b0;
      end
      // coalesce every following extent that touches
      while (idx + 1 < ext_n) begin
         ce = ext_s[idx] + ext_l[idx];
         if (ext_s[idx+1] > ce) break;
         e = ext_s[idx+1] + ext_l[idx+1];
         if (e > ce) ext_l[idx] = e - ext_s[idx];
         drop_extent(idx + 1);
      end
      return 1'b1;
   endfunction

   function automatic rsp_word_type predict_alloc(logic [CMD_W-1:0] cmd, int unsigned len,
                                                  int unsigned s, int unsigned fr);
      rsp_word_type r;
      int unsigned i, n, k;
      r.status = ST_OK;
      r.base = '0;
      if (cmd == CMD_ALLOC) begin
         if (len == 0) r.status = ST_ZERO_LEN;
         else if (in_use + len > cap) r.status = ST_NO_SPACE;
         else begin
            i = 0;
            while (i < ext_n && ext_l[i] < len) i++;
            if (i == ext_n) r.status = ST_NO_SPACE;
            else begin
               r.base = START_W'(ext_s[i]);
               if (ext_l[i] == len) drop_extent(i);
               else begin
                  ext_s[i] += len;
                  ext_l[i] -= len;
               end
               in_use += len;
            end
         end
      end else if (cmd == CMD_FREE) begin
         if (len == 0) r.status = ST_ZERO_LEN;
         else if (fr >= NFR || dq_n[fr] >= DDEP) r.status = ST_LIST_FULL;
         else begin
            if (len > 65536 - s) len = 65536 - s;
            dq_s[fr][dq_n[fr]] = s;
            dq_l[fr][dq_n[fr]] = len;
            dq_n[fr]++;
         end
      end else if (cmd == CMD_PROCESS && fr < NFR) begin
         n = dq_n[fr];
         for (i = 0; i < n; i++) begin
            if (!return_range(dq_s[fr][i], dq_l[fr][i])) break;
            in_use = (in_use >= dq_l[fr][i]) ? in_use - dq_l[fr][i] : 0;
         end
         if (i < n) begin
            r.status = ST_TABLE_FULL;
            for (k = 0; i + k < n; k++) begin
               dq_s[fr][k] = dq_s[fr][i+k];
               dq_l[fr][k] = dq_l[fr][i+k];
            end
            dq_n[fr] = k;
         end else dq_n[fr] = 0;
      end
      r.used = in_use[LEN_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else rsp_if.ready <= ($urandom_range(99) >= recv_stall);
   end

   // Compare each response word with the oldest expectation
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp.size() == 0) report_mismatch("unexpected word", 0, 0);
         else begin
            w = pending_rsp.pop_front();
            if (rsp_if.status !== w.status)
               report_mismatch("status", int'(rsp_if.status), int'(w.status));
            if (rsp_if.base_index !== w.base)
               report_mismatch("base_index", int'(rsp_if.base_index), int'(w.base));
            if (rsp_if.used_count !== w.used)
               report_mismatch("used_count", int'(rsp_if.used_count), int'(w.used));
         end
      end
   end

   task automatic send_word(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len,
                            logic [START_W-1:0] s, logic [FRAME_W-1:0] fr,
                            bit fixed, rsp_word_type want);
      rsp_word_type p;
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= cmd;
      req_if.length <= len;
      req_if.start_index <= s;
      req_if.frame <= fr;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      p = predict_alloc(cmd, len, s, fr);
      if (fixed && p !== want) report_mismatch("table row vs predictor", int'(p), int'(want));
      pending_rsp = {pending_rsp, (fixed ? want : p)};
   endtask

   // Drop valid and hold until every expected word is back
   task automatic wait_empty();
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic drain();
      wait_empty();
      repeat (40 * NEXT * DDEP) @(posedge clock);
   endtask

   task automatic write_capacity(logic [LEN_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap = (v == 0) ? 1 : (v > 65536 ? 65536 : v);
      shadow_init();
      @(posedge clock);
   endtask

   // Mostly well-formed traffic; sizes kept small for a busy table
   task automatic random_word(int unsigned big);
      int unsigned pick;
      logic [CMD_W-1:0] cmd;
      logic [LEN_W-1:0] len;
      logic [START_W-1:0] s;
      logic [FRAME_W-1:0] fr;
      pick = $urandom_range(99);
      fr = ($urandom_range(9) == 0) ? FRAME_W'($urandom_range(7))
                                    : FRAME_W'($urandom_range(NFR - 1));
      s = START_W'($urandom_range(big - 1));
      if ($urandom_range(19) == 0) len = LEN_W'($urandom);
      else len = LEN_W'($urandom_range(big / 8 + 1));
      if ($urandom_range(29) == 0) len = 0;
      if ($urandom_range(29) == 0) s = START_W'($urandom);
      if (pick < 45) cmd = CMD_ALLOC;
      else if (pick < 80) cmd = CMD_FREE;
      else if (pick < 97) cmd = CMD_PROCESS;
      else cmd = CMD_UNUSED;
      send_word(cmd, len, s, fr, 1'b0, '0);
   endtask

   stim_row_type rows[$];

   function automatic stim_row_type mk(logic [CMD_W-1:0] c, int unsigned l, int unsigned s,
                                       int unsigned f, bit fx, int unsigned st,
                                       int unsigned b, int unsigned u);
      stim_row_type r;
      r.cmd = c; r.len = LEN_W'(l); r.s = START_W'(s); r.fr = FRAME_W'(f); r.fixed = fx;
      r.want.status = STAT_W'(st); r.want.base = START_W'(b); r.want.used = LEN_W'(u);
      return r;
   endfunction

   initial begin
      req_if.valid = 1'b0;
      req_if.command = CMD_ALLOC;
      req_if.length = '0;
      req_if.start_index = '0;
      req_if.frame = '0;
      rsp_if.ready = 1'b0;
      cap = CAP_RESET;
      shadow_init();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table from reset capacity 1024
      rows = {rows, mk(CMD_ALLOC, 0, 0, 0, 1, ST_ZERO_LEN, 0, 0)};
      rows = {rows, mk(CMD_ALLOC, 1025, 0, 0, 1, ST_NO_SPACE, 0, 0)};
      rows = {rows, mk(CMD_ALLOC, 'h1ffff, 0, 0, 1, ST_NO_SPACE, 0, 0)};
      rows = {rows, mk(CMD_ALLOC, 100, 0, 0, 1, ST_OK, 0, 100)};
      rows = {rows, mk(CMD_ALLOC, 24, 0, 0, 1, ST_OK, 100, 124)};
      rows = {rows, mk(CMD_FREE, 0, 5, 0, 1, ST_ZERO_LEN, 0, 124)};
      rows = {rows, mk(CMD_FREE, 10, 0, 3, 1, ST_LIST_FULL, 0, 124)};
      rows = {rows, mk(CMD_FREE, 10, 0, 7, 1, ST_LIST_FULL, 0, 124)};
      rows = {rows, mk(CMD_PROCESS, 0, 0, 6, 1, ST_OK, 0, 124)};
      rows = {rows, mk(CMD_UNUSED, 5, 5, 0, 1, ST_OK, 0, 124)};
      rows = {rows, mk(CMD_FREE, 50, 0, 0, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_FREE, 50, 40, 0, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_FREE, 30, 94, 0, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_FREE, 'h1ffff, 'hffff, 1, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_PROCESS, 0, 0, 0, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_PROCESS, 0, 0, 1, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_ALLOC, 1024, 0, 0, 0, 0, 0, 0)};
      rows = {rows, mk(CMD_PROCESS, 0, 0, 2, 0, 0, 0, 0)};
      foreach (rows[i]) send_word(rows[i].cmd, rows[i].len, rows[i].s, rows[i].fr,
                                  rows[i].fixed, rows[i].want);

      // Table overflow: chop the space into many holes, then free them all
      write_capacity(17'd200);
      for (int i = 0; i < 40; i++) send_word(CMD_ALLOC, 5, 0, 0, 0, '0);
      for (int i = 0; i < 16; i++) send_word(CMD_FREE, 1, START_W'(10 * i), 0, 0, '0);
      for (int i = 0; i < 16; i++)
         send_word(CMD_FREE, 1, START_W'(10 * i + 163), 1, 0, '0);
      send_word(CMD_FREE, 1, 0, 1, 0, '0);
      send_word(CMD_PROCESS, 0, 0, 0, 0, '0);
      send_word(CMD_PROCESS, 0, 0, 1, 0, '0);
      send_word(CMD_PROCESS, 0, 0, 1, 0, '0);
      // full table: a range touching the next extent replaces it, a lone one fails
      send_word(CMD_FREE, 1, 312, 0, 0, '0);
      send_word(CMD_PROCESS, 0, 0, 0, 0, '0);
      send_word(CMD_FREE, 1, 400, 2, 0, '0);
      send_word(CMD_PROCESS, 0, 0, 2, 0, '0);
      send_word(CMD_PROCESS, 0, 0, 2, 0, '0);

      // Random phases over several capacities, extremes included
      for (int ph = 0; ph < 8; ph++) begin
         int unsigned big;
         case (ph)
            0: begin write_capacity(17'd0); send_idle = 0; recv_stall = 0; end
            1: begin write_capacity(17'h1ffff); send_idle = 52; recv_stall = 0; end
            2: begin write_capacity(17'h10000); send_idle = 0; recv_stall = 52; end
            3: begin write_capacity(17'd1024); send_idle = 36; recv_stall = 36; end
            4: begin write_capacity(17'd300); send_idle = 0; recv_stall = 0; end
            5: begin write_capacity(17'd1); send_idle = 52; recv_stall = 52; end
            6: begin write_capacity(17'd5000); send_idle = 36; recv_stall = 36; end
            default: begin write_capacity(17'd777); send_idle = 0; recv_stall = 0; end
         endcase
         big = (cap > 2000) ? 2000 : cap;
         if (ph == 1) big = 65536;
         if (ph == 4) hold_cycles <= 400;
         for (int i = 0; i < 165; i++) begin
            random_word(big);
            if (i == 80) begin
               // pause until every response is back
               wait_empty();
            end
         end
      end

      drain();
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/ffea_pkg.sv
rtl/ffea_req_if.sv
rtl/ffea_rsp_if.sv
rtl/ffea_cell.sv
rtl/ffea_defer_mem.sv
rtl/first_fit_extent_allocator.sv
sim/testbench.sv
